>>> rtl/wsx_pkg.sv
// shared types, codes and constants for the wav stream sample extractor
package wsx_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 112;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    localparam logic [15:0] BITS_8  = 16'd8;
    localparam logic [15:0] BITS_16 = 16'd16;
    localparam logic [15:0] BITS_24 = 16'd24;
    localparam logic [15:0] BITS_32 = 16'd32;

    typedef enum logic [1:0] {
        KIND_SAMPLE     = 2'd0,
        KIND_INFO       = 2'd1,
        KIND_BAD_TAG    = 2'd2,
        KIND_BAD_FORMAT = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_ID    = 4'd3,
        PH_SIZE  = 4'd4,
        PH_FMT   = 4'd5,
        PH_SKIP  = 4'd6,
        PH_DATA  = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] sample_q31;
        logic [15:0]        channel_count;
        logic [31:0]        rate_hz;
        logic [15:0]        sample_bits;
        logic [15:0]        format_code;
    } wsx_result_t;

endpackage

>>> rtl/wav_stream_sample_extractor.sv
// top level of the wav byte stream parser and q1.31 sample extractor
//
//  channel | direction | tdata                    | tuser      | per transfer
//  s_      | in        | data_byte                | file_start | one file byte
//  m_      | out       | sample, fmt, stream info | kind       | zero or one result
//
// one byte is taken every cycle while s_tready is high; a result passes the result register or the skid entry before m_
// the parser state and the result register or skid entry update in the cycle of the transfer
// s_tready drops only while both the result register and the skid entry are full
// aresetn clears the parser to the riff tag phase and empties the output side
// file_start on a byte restarts parsing with that byte
module wav_stream_sample_extractor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wsx_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                          s_tuser,  // [0] file_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] sample_q31, [47:32] channel_count, [79:48] rate_hz,
    // [95:80] sample_bits, [111:96] format_code
    output logic [wsx_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser   // [1:0] kind
);
    import wsx_pkg::*;

    logic        accept;
    logic        res_valid;
    wsx_result_t res;
    wsx_result_t out_res;

    assign accept = s_tvalid && s_tready;

    wsx_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_tdata[7:0]),
        .file_start (s_tuser),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsx_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && res_valid),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.format_code, out_res.sample_bits, out_res.rate_hz,
                      out_res.channel_count, out_res.sample_q31};
    assign m_tuser = out_res.kind;

endmodule

>>> rtl/wsx_sample_conv.sv
// sample word to q1.31 conversion for integer and float formats
module wsx_sample_conv (
    input  logic [31:0]        gather,
    input  logic [15:0]        fmt_format,
    input  logic [15:0]        fmt_bits,
    output logic signed [31:0] sample_q31
);
    import wsx_pkg::*;

    logic [7:0]  u8_mag;
    logic [32:0] u8_q;
    logic [31:0] u8_res;
    logic [7:0]  f_ex;
    logic [22:0] f_frac;
    logic        f_neg;
    logic [23:0] f_mant;
    logic [7:0]  f_e;
    logic [7:0]  f_up;
    logic [7:0]  f_dn;
    logic [31:0] f_rnd;
    logic [31:0] f_mag;
    logic [31:0] f_res;

    // 8-bit: |2v-255| * 0x808080 + (|2v-255|+1)/2
    always_comb begin
        u8_mag = gather[7] ? {gather[6:0], 1'b1} : ~{gather[6:0], 1'b0};
        u8_q   = {2'b0, u8_mag, 23'b0} + {10'b0, u8_mag, 15'b0} + {18'b0, u8_mag, 7'b0}
               + {26'b0, u8_mag[7:1]} + 33'd1;
        if (gather[7]) begin
            u8_res = u8_q[32:31] != 2'b00 ? 32'h7FFF_FFFF : u8_q[31:0];
        end else begin
            u8_res = 32'd0 - u8_q[31:0];
        end
    end

    always_comb begin
        f_ex   = gather[30:23];
        f_frac = gather[22:0];
        f_neg  = gather[31];
        f_mant = (f_ex != 8'd0) ? {1'b1, f_frac} : {1'b0, f_frac};
        f_e    = (f_ex != 8'd0) ? f_ex : 8'd1;
        f_up   = f_e - 8'd119;
        f_dn   = 8'd119 - f_e;
        f_rnd  = '0;
        if (f_e >= 8'd119) begin
            f_mag = {8'b0, f_mant} << f_up[2:0];
        end else if (f_dn > 8'd24) begin
            f_mag = '0;
        end else begin
            f_rnd = {8'b0, f_mant} + (32'd1 << (f_dn[4:0] - 5'd1));
            f_mag = f_rnd >> f_dn[4:0];
        end
        if (f_ex == 8'd255 && f_frac != 23'd0) begin
            f_res = '0;
        end else if (f_ex >= 8'd127) begin
            f_res = f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            f_res = f_neg ? 32'd0 - f_mag : f_mag;
        end
    end

    always_comb begin
        if (fmt_format == FMT_FLOAT) begin
            sample_q31 = f_res;
        end else begin
            case (fmt_bits)
                BITS_8:  sample_q31 = u8_res;
                BITS_16: sample_q31 = {gather[15:0], 16'b0};
                BITS_24: sample_q31 = {gather[23:0], 8'b0};
                default: sample_q31 = gather;
            endcase
        end
    end

endmodule

>>> rtl/wsx_parser.sv
// riff/wave chunk walker with fmt capture and sample gathering
module wsx_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 file_start,
    output logic                 res_valid,
    output wsx_pkg::wsx_result_t res
);
    import wsx_pkg::*;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [3:0]  pos_reg, pos_next, cur_pos;
    logic [31:0] tag_reg, tag_next, cur_tag;
    logic [31:0] rem_reg, rem_next, cur_rem;
    logic [15:0] fmt_format_reg, fmt_format_next, cur_format;
    logic [15:0] fmt_channels_reg, fmt_channels_next, cur_channels;
    logic [31:0] fmt_rate_reg, fmt_rate_next, cur_rate;
    logic [15:0] fmt_bits_reg, fmt_bits_next, cur_bits;
    logic [31:0] gather_reg, gather_next, cur_gather;

    logic [1:0]         pos2;
    logic [31:0]        tag_new;
    logic [31:0]        gather_new;
    logic [31:0]        rem_new;
    logic [31:0]        rem_dec;
    logic [4:0]         fmt_pos_inc;
    logic [2:0]         data_pos_inc;
    logic [2:0]         need;
    logic               fmt_ok;
    logic signed [31:0] conv_q31;

    wsx_sample_conv u_conv (
        .gather     (gather_new),
        .fmt_format (cur_format),
        .fmt_bits   (cur_bits),
        .sample_q31 (conv_q31)
    );

    always_comb begin
        cur_phase    = file_start ? PH_RIFF : phase_reg;
        cur_pos      = file_start ? 4'd0 : pos_reg;
        cur_tag      = file_start ? 32'd0 : tag_reg;
        cur_rem      = file_start ? 32'd0 : rem_reg;
        cur_format   = file_start ? 16'd0 : fmt_format_reg;
        cur_channels = file_start ? 16'd0 : fmt_channels_reg;
        cur_rate     = file_start ? 32'd0 : fmt_rate_reg;
        cur_bits     = file_start ? 16'd0 : fmt_bits_reg;
        cur_gather   = file_start ? 32'd0 : gather_reg;

        pos2         = cur_pos[1:0];
        tag_new      = {cur_tag[23:0], data_byte};
        gather_new   = cur_gather | ({24'b0, data_byte} << {pos2, 3'b0});
        rem_new      = cur_rem | ({24'b0, data_byte} << {pos2, 3'b0});
        rem_dec      = cur_rem - 32'd1;
        fmt_pos_inc  = {1'b0, cur_pos} + 5'd1;
        data_pos_inc = {1'b0, pos2} + 3'd1;
        need         = (cur_bits[5:3] == 3'd0 || cur_bits[5:3] > 3'd4) ? 3'd4 : cur_bits[5:3];

        if (cur_channels == 16'd0) begin
            fmt_ok = 1'b0;
        end else if (cur_format == FMT_FLOAT) begin
            fmt_ok = cur_bits == BITS_32;
        end else if (cur_format == FMT_PCM) begin
            fmt_ok = cur_bits == BITS_8 || cur_bits == BITS_16
                  || cur_bits == BITS_24 || cur_bits == BITS_32;
        end else begin
            fmt_ok = 1'b0;
        end

        phase_next        = cur_phase;
        pos_next          = cur_pos;
        tag_next          = cur_tag;
        rem_next          = cur_rem;
        fmt_format_next   = cur_format;
        fmt_channels_next = cur_channels;
        fmt_rate_next     = cur_rate;
        fmt_bits_next     = cur_bits;
        gather_next       = cur_gather;

        res_valid         = 1'b0;
        res.kind          = KIND_SAMPLE;
        res.sample_q31    = '0;
        res.channel_count = '0;
        res.rate_hz       = '0;
        res.sample_bits   = cur_bits;
        res.format_code   = cur_format;

        case (cur_phase)
            PH_RIFF, PH_WAVE, PH_ID: begin
                tag_next = tag_new;
                if (pos2 != 2'd3) begin
                    pos_next = {2'b0, pos2} + 4'd1;
                end else begin
                    pos_next = '0;
                    if (cur_phase == PH_ID) begin
                        rem_next   = '0;
                        phase_next = PH_SIZE;
                    end else if (tag_new != (cur_phase == PH_RIFF ? TAG_RIFF : TAG_WAVE)) begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_BAD_TAG;
                    end else begin
                        phase_next = (cur_phase == PH_RIFF) ? PH_RSIZE : PH_ID;
                    end
                end
            end
            PH_RSIZE: begin
                if (pos2 != 2'd3) begin
                    pos_next = {2'b0, pos2} + 4'd1;
                end else begin
                    pos_next   = '0;
                    phase_next = PH_WAVE;
                end
            end
            PH_SIZE: begin
                rem_next = rem_new;
                if (pos2 != 2'd3) begin
                    pos_next = {2'b0, pos2} + 4'd1;
                end else begin
                    pos_next = '0;
                    if (cur_tag == TAG_DATA) begin
                        res_valid = 1'b1;
                        if (!fmt_ok) begin
                            phase_next = PH_DONE;
                            res.kind   = KIND_BAD_FORMAT;
                        end else begin
                            gather_next       = '0;
                            phase_next        = (rem_new != 32'd0) ? PH_DATA : PH_DONE;
                            res.kind          = KIND_INFO;
                            res.channel_count = cur_channels;
                            res.rate_hz       = cur_rate;
                        end
                    end else if (cur_tag == TAG_FMT) begin
                        fmt_format_next   = '0;
                        fmt_channels_next = '0;
                        fmt_rate_next     = '0;
                        fmt_bits_next     = '0;
                        phase_next        = (rem_new != 32'd0) ? PH_FMT : PH_ID;
                    end else begin
                        phase_next = (rem_new != 32'd0) ? PH_SKIP : PH_ID;
                    end
                end
            end
            PH_FMT: begin
                if (cur_pos < 4'd2) begin
                    fmt_format_next = cur_format
                                    | ({8'b0, data_byte} << {cur_pos[0], 3'b0});
                end else if (cur_pos < 4'd4) begin
                    fmt_channels_next = cur_channels
                                      | ({8'b0, data_byte} << {cur_pos[0], 3'b0});
                end else if (cur_pos < 4'd8) begin
                    fmt_rate_next = cur_rate
                                  | ({24'b0, data_byte} << {cur_pos[1:0], 3'b0});
                end else if (cur_pos >= 4'd14) begin
                    fmt_bits_next = cur_bits
                                  | ({8'b0, data_byte} << {cur_pos[0], 3'b0});
                end
                rem_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    pos_next   = '0;
                    phase_next = PH_ID;
                end else if (fmt_pos_inc[4]) begin
                    pos_next   = '0;
                    phase_next = PH_SKIP;
                end else begin
                    pos_next = fmt_pos_inc[3:0];
                end
            end
            PH_SKIP: begin
                rem_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    pos_next   = '0;
                    phase_next = PH_ID;
                end
            end
            PH_DATA: begin
                rem_next = rem_dec;
                if (data_pos_inc >= need) begin
                    res_valid      = 1'b1;
                    res.sample_q31 = conv_q31;
                    pos_next       = '0;
                    gather_next    = '0;
                end else begin
                    pos_next    = {1'b0, data_pos_inc};
                    gather_next = gather_new;
                end
                if (rem_dec == 32'd0) begin
                    phase_next = PH_DONE;
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_RIFF;
            pos_reg          <= '0;
            tag_reg          <= '0;
            rem_reg          <= '0;
            fmt_format_reg   <= '0;
            fmt_channels_reg <= '0;
            fmt_rate_reg     <= '0;
            fmt_bits_reg     <= '0;
            gather_reg       <= '0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            tag_reg          <= tag_next;
            rem_reg          <= rem_next;
            fmt_format_reg   <= fmt_format_next;
            fmt_channels_reg <= fmt_channels_next;
            fmt_rate_reg     <= fmt_rate_next;
            fmt_bits_reg     <= fmt_bits_next;
            gather_reg       <= gather_next;
        end
    end

endmodule

>>> rtl/wsx_out_buf.sv
// result register with one skid entry
module wsx_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  wsx_pkg::wsx_result_t push_data,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wsx_pkg::wsx_result_t out_data
);
    import wsx_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    wsx_result_t out_data_reg, out_data_next;
    wsx_result_t skid_data_reg, skid_data_next;
    logic        out_take;

    always_comb begin
        out_take        = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || out_take) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/wsx_checker.sv
// port-level checks for the wav stream sample extractor, bound to the top level
module wsx_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [wsx_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wsx_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);
    import wsx_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    a_info_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_INFO |-> m_tdata[79:32] == 48'd0)
        else $error("channel or rate set outside stream info");

    a_sample_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_SAMPLE |-> m_tdata[31:0] == 32'd0)
        else $error("sample set outside sample result");

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tuser ^ (^s_tdata);

endmodule

bind wav_stream_sample_extractor wsx_checker u_wsx_checker (.*);
